>>> hw/rtl/spc_pkg.sv
// Shared widths, types and constants for the sphere pair contact pipeline.
// No dependencies; imported by every module of the block.
package spc_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int DIFF_W   = 33;   // magnitude of a centre difference
  localparam int SQ_W     = 66;   // sum of three squared differences
  localparam int TRIAL_W  = 70;   // trial term of the root recurrence
  localparam int ROOT_W   = 35;   // floor square root
  localparam int Q_BITS   = 15;   // normal quotient, at most 2^14
  localparam int DIVN_W   = DIFF_W + 14;
  localparam int DSH_W    = ROOT_W + Q_BITS;
  localparam int NRM_W    = 16;
  localparam int PEN_W    = 33;
  localparam int TAG_W    = 16;
  localparam int LIMIT_W  = 16;
  localparam int IN_DATA_W  = 288;
  localparam int OUT_DATA_W = 216;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1;
  localparam logic [NRM_W-1:0] NORMAL_ONE = 16'sd16384;
  localparam logic [2:0] ADDR_LIMIT = 3'd0;

  // pipeline advance and item valid, handed to each stage group
  typedef struct packed {
    logic adv;
    logic valid;
  } pipe_ctl_t;

  // item context carried alongside the arithmetic
  typedef struct packed {
    logic                   hit;
    logic [2:0]             dneg;
    logic [2:0][DIFF_W-1:0] dmag;
    logic [2:0][31:0]       point;
    logic [31:0]            rsum;
    logic [TAG_W-1:0]       tag1;
    logic [TAG_W-1:0]       tag2;
  } ctx_t;

endpackage

>>> hw/rtl/spc_sqrt_pipe.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on spc_pkg for widths and the context type.
module spc_sqrt_pipe import spc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  pipe_ctl_t         ctl,
  input  logic [SQ_W-1:0]   sq,
  input  ctx_t              ctx_in,
  output logic              vld_out,
  output logic [ROOT_W-1:0] root,
  output ctx_t              ctx_out
);

  logic              vld [0:ROOT_W];
  logic [SQ_W-1:0]   rem [0:ROOT_W];
  logic [ROOT_W-1:0] rt  [0:ROOT_W];
  ctx_t              cx  [0:ROOT_W];

  assign vld[0] = ctl.valid;
  assign rem[0] = sq;
  assign rt[0]  = '0;
  assign cx[0]  = ctx_in;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [TRIAL_W-1:0] trial;
    logic [TRIAL_W-1:0] rem_w;
    logic               take;

    // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
    assign trial = (TRIAL_W'(rt[k]) << (B + 1)) | (TRIAL_W'(1) << (2 * B));
    assign rem_w = TRIAL_W'(rem[k]);
    assign take  = rem_w >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ctl.adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        rem[k+1] <= take ? SQ_W'(rem_w - trial) : rem[k];
        rt[k+1]  <= take ? (rt[k] | (ROOT_W'(1) << B)) : rt[k];
        cx[k+1]  <= cx[k];
      end
    end
  end

  assign vld_out = vld[ROOT_W];
  assign root    = rt[ROOT_W];
  assign ctx_out = cx[ROOT_W];

endmodule

>>> hw/rtl/spc_div_pipe.sv
// Pipelined restoring division of the three difference magnitudes by the root.
// Depends on spc_pkg; one quotient bit per register stage, three lanes.
module spc_div_pipe import spc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  pipe_ctl_t              ctl,
  input  logic [ROOT_W-1:0]      root_in,
  input  ctx_t                   ctx_in,
  output logic                   vld_out,
  output logic [2:0][Q_BITS-1:0] quot,
  output logic [ROOT_W-1:0]      root_out,
  output ctx_t                   ctx_out
);

  logic                   vld [0:Q_BITS];
  logic [2:0][DIVN_W-1:0] rem [0:Q_BITS];
  logic [2:0][Q_BITS-1:0] qt  [0:Q_BITS];
  logic [ROOT_W-1:0]      rt  [0:Q_BITS];
  ctx_t                   cx  [0:Q_BITS];

  assign vld[0] = ctl.valid;
  assign rt[0]  = root_in;
  assign cx[0]  = ctx_in;
  assign qt[0]  = '0;
  for (genvar l = 0; l < 3; l++) begin : g_init
    assign rem[0][l] = {ctx_in.dmag[l], 14'b0};
  end

  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    localparam int B = Q_BITS - 1 - k;
    logic [DSH_W-1:0] dsh;
    assign dsh = DSH_W'(rt[k]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ctl.adv) begin
        vld[k+1] <= vld[k];
      end
    end

    // one compare and subtract per lane
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DSH_W-1:0] rem_w;
      logic             take;
      assign rem_w = DSH_W'(rem[k][l]);
      assign take  = rem_w >= dsh;

      always_ff @(posedge clk) begin
        if (ctl.adv) begin
          rem[k+1][l] <= take ? DIVN_W'(rem_w - dsh) : rem[k][l];
          qt[k+1][l]  <= take ? (qt[k][l] | (Q_BITS'(1) << B)) : qt[k][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        rt[k+1] <= rt[k];
        cx[k+1] <= cx[k];
      end
    end
  end

  assign vld_out  = vld[Q_BITS];
  assign quot     = qt[Q_BITS];
  assign root_out = rt[Q_BITS];
  assign ctx_out  = cx[Q_BITS];

endmodule

>>> hw/rtl/sphere_pair_contact.sv
// Sphere pair contact: a registered pipeline from input transfer to output valid
// (3 front stages, 35 root stages, 15 divide stages, output register).
// Throughput one pair per cycle; the whole pipeline halts while a result waits.
// Synchronous active-high reset clears valid bits and sets limit to 1.
// Depends on spc_pkg, spc_sqrt_pipe and spc_div_pipe.
module sphere_pair_contact import spc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // fields from bit 0: first_center_x/y/z, second_center_x/y/z, first_radius,
  // second_radius, first_body_tag, second_body_tag, zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // fields from bit 0: normal_x/y/z, point_x/y/z, penetration, tag_out_first,
  // tag_out_second, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [0:0]            m_tuser,  // hit
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;

  // configuration register
  logic [LIMIT_W-1:0] limit;
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LIMIT) ? {16'b0, limit} : 32'b0;
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_LIMIT) begin
      limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // global advance: move whenever the output register is empty or being taken
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: differences, midpoints, radius sum
  logic signed [32:0] p1 [3];
  logic signed [32:0] p2 [3];
  logic signed [32:0] dd [3];
  logic signed [32:0] ps [3];
  for (genvar i = 0; i < 3; i++) begin : g_diff
    assign p1[i] = $signed(s_tdata[32*i +: CW]);
    assign p2[i] = $signed(s_tdata[96 + 32*i +: CW]);
    assign dd[i] = p1[i] - p2[i];
    assign ps[i] = p1[i] + p2[i];
  end

  logic v1;
  ctx_t c1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c1.dneg[i]  <= dd[i][32];
        c1.dmag[i]  <= dd[i][32] ? DIFF_W'(-dd[i]) : DIFF_W'(dd[i]);
        c1.point[i] <= ps[i][32:1];
      end
      c1.hit  <= 1'b0;
      c1.rsum <= 32'(s_tdata[222:192]) + 32'(s_tdata[253:223]);
      c1.tag1 <= s_tdata[269:254];
      c1.tag2 <= s_tdata[285:270];
    end
  end

  // stage 2: squares
  logic v2;
  ctx_t c2;
  logic [SQ_W-1:0] sq2 [3];
  logic [63:0] rsq2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= SQ_W'(c1.dmag[i]) * SQ_W'(c1.dmag[i]);
      end
      rsq2 <= 64'(c1.rsum) * 64'(c1.rsum);
      c2   <= c1;
    end
  end

  // stage 3: distance squared and contact test
  logic [SQ_W-1:0] ssum;
  assign ssum = sq2[0] + sq2[1] + sq2[2];
  ctx_t c2h;
  always_comb begin
    c2h     = c2;
    c2h.hit = ssum <= SQ_W'(rsq2);
  end
  logic v3;
  ctx_t c3;
  logic [SQ_W-1:0] sq3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sq3 <= ssum;
      c3  <= c2h;
    end
  end

  // square root
  pipe_ctl_t ctl_sq;
  assign ctl_sq = '{adv: adv, valid: v3};
  logic              v4;
  logic [ROOT_W-1:0] root4;
  ctx_t              c4;
  spc_sqrt_pipe u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl_sq),
    .sq     (sq3),
    .ctx_in (c3),
    .vld_out(v4),
    .root   (root4),
    .ctx_out(c4)
  );

  // normal division
  pipe_ctl_t ctl_dv;
  assign ctl_dv = '{adv: adv, valid: v4};
  logic                   v5;
  logic [2:0][Q_BITS-1:0] q5;
  logic [ROOT_W-1:0]      root5;
  ctx_t                   c5;
  spc_div_pipe u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_dv),
    .root_in (root4),
    .ctx_in  (c4),
    .vld_out (v5),
    .quot    (q5),
    .root_out(root5),
    .ctx_out (c5)
  );

  // result assembly
  logic               use_div;
  logic [NRM_W-1:0]   nrm [3];
  logic [ROOT_W-1:0]  pen_w;
  assign use_div = root5 > ROOT_W'(limit);
  assign pen_w   = ROOT_W'(c5.rsum) - root5;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm[i] = c5.dneg[i] ? NRM_W'(-NRM_W'(q5[i])) : NRM_W'(q5[i]);
    end
    if (!use_div) begin
      nrm[0] = NORMAL_ONE;
      nrm[1] = '0;
      nrm[2] = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v5;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tuser <= c5.hit;
      if (c5.hit) begin
        m_tdata <= {7'b0, c5.tag2, c5.tag1, pen_w[PEN_W-1:0],
                    c5.point[2], c5.point[1], c5.point[0], nrm[2], nrm[1], nrm[0]};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

>>> tb/tb_top.sv
// Self-checking bench for sphere_pair_contact: drives sphere pairs, predicts contacts.
// Depends on spc_pkg and the sphere_pair_contact RTL.
`timescale 1ns / 100ps
module tb_top;
  import spc_pkg::*;

  typedef struct packed {
    logic [15:0] tag2;
    logic [15:0] tag1;
    logic [30:0] r2;
    logic [30:0] r1;
    logic [2:0][31:0] p2;
    logic [2:0][31:0] p1;
  } pair_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] tag2;
    logic [15:0] tag1;
    logic [32:0] pen;
    logic [2:0][31:0] pt;
    logic [2:0][15:0] nrm;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pair_t    pending_pairs[$];
  contact_t expected_contacts[$];
  logic [15:0] limit_model = 16'd1;
  int errors = 0;
  int contacts_seen = 0;
  int hits_seen = 0;
  int hold_cycles = 0;
  bit stall_free = 1'b0;
  bit hold_armed = 1'b0;

  always #5 clk = ~clk;

  sphere_pair_contact u_dut (.*);

  // floor square root of a 66-bit value
  function automatic logic [34:0] root_floor(logic [65:0] v);
    logic [34:0] r;
    logic [34:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (35'd1 << b);
      if ({35'd0, c} * {35'd0, c} <= {4'd0, v}) r = c;
    end
    return r;
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    logic signed [33:0] d[3];
    logic [32:0] mag[3];
    logic [65:0] sq;
    logic [31:0] rsum;
    logic [65:0] rsq;
    logic [34:0] root_len;
    logic [47:0] q;
    logic signed [32:0] s;
    c = '0;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed(p.p1[i]) - $signed(p.p2[i]);
      mag[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
      sq += {33'd0, mag[i]} * {33'd0, mag[i]};
    end
    rsum = {1'b0, p.r1} + {1'b0, p.r2};
    rsq = {34'd0, rsum} * {34'd0, rsum};
    if (sq > rsq) return c;
    root_len = root_floor(sq);
    c.hit = 1'b1;
    if (root_len > {19'd0, limit_model}) begin
      for (int i = 0; i < 3; i++) begin
        q = ({15'd0, mag[i]} << 14) / {13'd0, root_len};
        c.nrm[i] = d[i] < 0 ? 16'(-q) : q[15:0];
      end
    end else begin
      c.nrm[0] = NORMAL_ONE;
    end
    for (int i = 0; i < 3; i++) begin
      s = $signed(p.p1[i]) + $signed(p.p2[i]);
      c.pt[i] = s[32:1];
    end
    c.pen = {1'b0, rsum} - root_len[32:0];
    c.tag1 = p.tag1;
    c.tag2 = p.tag2;
    return c;
  endfunction

  // sender: feed pairs from the queue with random gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready) begin
        if (pending_pairs.size() > 0 && (stall_free || $urandom_range(99) >= 21)) begin
          pair_t p;
          p = pending_pairs.pop_front();
          s_tdata <= {{(IN_DATA_W - 286){1'b0}}, p[285:0]};
          s_tvalid <= 1'b1;
          expected_contacts.insert(expected_contacts.size(), predict_contact(p));
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure, with one long hold-off
  always @(posedge clk) begin
    if (hold_armed && hold_cycles < 300) begin
      hold_cycles <= hold_cycles + 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst && (stall_free || $urandom_range(99) >= 21);
    end
  end

  // checker: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      contact_t got;
      contact_t exp_c;
      got = {m_tuser[0], m_tdata[208:0]};
      contacts_seen <= contacts_seen + 1;
      if (got.hit) hits_seen <= hits_seen + 1;
      if (expected_contacts.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors <= errors + 1;
      end else begin
        exp_c = expected_contacts.pop_front();
        if (got !== exp_c) begin
          $display("%0t: mismatch hit %b/%b nrm %h/%h pt %h/%h pen %h/%h tags %h%h/%h%h",
                   $realtime, exp_c.hit, got.hit, exp_c.nrm, got.nrm, exp_c.pt, got.pt,
                   exp_c.pen, got.pen, exp_c.tag1, exp_c.tag2, got.tag1, got.tag2);
          errors <= errors + 1;
        end
      end
    end
  end

  task automatic write_limit(logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_LIMIT; pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    limit_model = v;
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || expected_contacts.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(200000)) - 100000);
      default: return 32'($signed($urandom_range(8000)) - 4000);
    endcase
  endfunction

  // mostly touching pairs near each other, some far-flung noise
  function automatic pair_t random_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(9) < 2 ? 0 : ($urandom_range(1) ? 1 : 2);
    for (int i = 0; i < 3; i++) begin
      p.p1[i] = rand_coord(mode);
      p.p2[i] = $urandom_range(9) == 0 ? p.p1[i] : p.p1[i] + rand_coord(mode == 0 ? 1 : mode);
    end
    if (mode == 0) begin
      p.r1 = 31'($urandom()); p.r2 = 31'($urandom());
    end else begin
      p.r1 = 31'($urandom_range(mode == 1 ? 200000 : 6000));
      p.r2 = 31'($urandom_range(mode == 1 ? 200000 : 6000));
    end
    p.tag1 = 16'($urandom()); p.tag2 = 16'($urandom());
    return p;
  endfunction

  task automatic add_pair(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                          logic [31:0] e, logic [31:0] f, logic [31:0] g,
                          logic [31:0] r1, logic [31:0] r2);
    pair_t p;
    p.p1 = {c, b, a}; p.p2 = {g, f, e}; p.r1 = r1[30:0]; p.r2 = r2[30:0];
    p.tag1 = 16'($urandom()); p.tag2 = 16'($urandom());
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  initial begin
    logic [15:0] limits[4];
    limits = '{16'd0, 16'hFFFF, 16'd300, 16'd1};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, coincident centres, exact touch, tiny distances
    add_pair(0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 10, 10);
    add_pair(1, 0, 0, 0, 0, 0, 1, 0);
    add_pair(2, 0, 0, 0, 0, 0, 1, 0);
    add_pair(0, 0, 3, 0, 0, 0, 0, 3);
    add_pair(0, 32'hFFFF_0000, 0, 0, 0, 0, 32'h10000, 0);
    add_pair(32'h30000, 32'h40000, 0, 0, 0, 0, 32'h50000, 0);
    add_pair(32'h30000, 32'h40000, 0, 0, 0, 0, 32'h4FFFF, 0);
    add_pair(5, 5, 5, 5, 5, 5, 32'h7FFF_FFFF, 0);
    add_pair(32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0, 0, 0);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      stall_free = (ph == 2);
      hold_armed = (ph == 1);
      for (int n = 0; n < 385; n++) pending_pairs.insert(pending_pairs.size(), random_pair());
      drain();
    end
    $display("covered %0d contacts (%0d hits) over limits 1, 0, 65535, 300, 1",
             contacts_seen, hits_seen);
    if (errors == 0 && expected_contacts.size() == 0) begin
      $display("sphere_pair_contact test passed");
    end else begin
      $display("sphere_pair_contact test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sphere_pair_contact test failed");
    $finish;
  end
endmodule
